>>> hw/rtl/thc_pkg.sv
// ---------------------------------------------------------------------------
// thc_pkg
// Shared types and constants for the tilt-compensated heading pipeline.
// ---------------------------------------------------------------------------
package thc_pkg;

  // Angles are Q16 radians; trig outputs are Q16 values near unit magnitude.
  localparam int ANG_W    = 20;
  localparam int TRIG_W   = 20;
  localparam int ATAN_LEN = 25;

  // Arctangent table: round(atan(2^-i) * 2^16).
  localparam logic signed [ANG_W-1:0] ATAN_TABLE [ATAN_LEN] = '{
    20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
    20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32, 20'sd16,
    20'sd8, 20'sd4, 20'sd2, 20'sd1, 20'sd0, 20'sd0, 20'sd0, 20'sd0,
    20'sd0, 20'sd0, 20'sd0, 20'sd0
  };

  localparam logic signed [ANG_W-1:0]  PI_Q16       = 20'sd205887;
  localparam logic signed [TRIG_W-1:0] GAIN_INV_Q16 = 20'sd39797;

  // round(18000/pi * 2^16), used with a 2^32 scale to reach centidegrees.
  localparam int CD_K_W = 29;
  localparam logic [CD_K_W-1:0] CD_PER_RAD = 29'd375493621;
  localparam logic [15:0]       CD_MAX     = 16'd18000;

  // Square root of a 64-bit operand, one result bit per stage.
  localparam int ISQ_W     = 64;
  localparam int ISQ_STEPS = 32;

endpackage

>>> hw/rtl/tilt_compensated_heading.sv
// Throughput: one item per cycle while the output is not stalled; every stage is registered and advances together.
// The 32-stage square root and the three CORDIC chains set the depth.
// A stalled output holds the whole pipeline; in_ready is low only then.
// Reset clears all valid bits; data registers are not reset.
// ---------------------------------------------------------------------------
// tilt_compensated_heading
// Compass heading from one magnetometer sample: roll and pitch from the
// vector itself, rotation by those angles, then atan2 in centidegrees.
// ---------------------------------------------------------------------------
module tilt_compensated_heading import thc_pkg::*; #(
  parameter int CORDIC_STAGES = 16,
  parameter int SAMPLE_WIDTH  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] mag_x,
  input  logic signed [15:0] mag_y,
  input  logic signed [15:0] mag_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] heading_centideg
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int SH    = 32 - SAMPLE_WIDTH;
  localparam int RAW_W = (SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH : 16;
  localparam int SQ_W  = 2 * SAMPLE_WIDTH;
  localparam int TW    = 33;
  localparam int PW    = SAMPLE_WIDTH + TRIG_W;
  localparam int FW    = 2 * TRIG_W - 16;
  localparam int MW    = SAMPLE_WIDTH + FW;
  localparam int W2    = SAMPLE_WIDTH + 20;
  localparam int CPW   = ANG_W + CD_K_W;

  // Low SAMPLE_WIDTH bits of the raw field, sign-extended from the top one.
  function automatic logic signed [SAMPLE_WIDTH-1:0] to_sample(input logic [15:0] raw);
    logic [RAW_W-1:0] ext;
    ext = RAW_W'(raw);
    return $signed(ext[SAMPLE_WIDTH-1:0]);
  endfunction

  function automatic logic [ISQ_W-1:0] isq_bit(input int k);
    return 64'd1 << (62 - 2 * k);
  endfunction

  logic en;
  logic c2_v;

  // The whole pipeline moves unless the output register holds an untaken item.
  assign en        = !c2_v || out_ready;
  assign in_ready  = en;
  assign out_valid = c2_v;

  // Stage 1: samples and their squares.
  logic                   s1_v;
  logic signed [SW-1:0]   s1_x, s1_y, s1_z;
  logic [SQ_W-1:0]        s1_xx, s1_yy, s1_zz;
  logic signed [SW-1:0]   in_x, in_y, in_z;
  logic signed [SQ_W-1:0] px, py, pz;

  assign in_x = to_sample(mag_x);
  assign in_y = to_sample(mag_y);
  assign in_z = to_sample(mag_z);
  assign px   = in_x * in_x;
  assign py   = in_y * in_y;
  assign pz   = in_z * in_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x  <= in_x;
      s1_y  <= in_y;
      s1_z  <= in_z;
      s1_xx <= $unsigned(px);
      s1_yy <= $unsigned(py);
      s1_zz <= $unsigned(pz);
    end
  end

  // Square roots of the two scaled sums, one result bit per stage.
  // Lane 0 feeds roll (x^2 + z^2), lane 1 feeds pitch (y^2 + z^2).
  logic [SQ_W-1:0]      sum_roll, sum_pitch;
  logic [ISQ_W-1:0]     rem_q [2][ISQ_STEPS+1];
  logic [ISQ_W-1:0]     res_q [2][ISQ_STEPS+1];
  logic [ISQ_W-1:0]     trial [2][ISQ_STEPS];
  logic signed [SW-1:0] sq_x [ISQ_STEPS+1];
  logic signed [SW-1:0] sq_y [ISQ_STEPS+1];
  logic signed [SW-1:0] sq_z [ISQ_STEPS+1];
  logic [ISQ_STEPS:0]   sq_v;

  assign sum_roll  = s1_xx + s1_zz;
  assign sum_pitch = s1_yy + s1_zz;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      for (int k = 0; k < ISQ_STEPS; k++) begin
        trial[l][k] = res_q[l][k] + isq_bit(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v <= '0;
    end else if (en) begin
      sq_v <= {sq_v[ISQ_STEPS-1:0], s1_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0][0] <= {sum_roll, {(2 * SH){1'b0}}};
      rem_q[1][0] <= {sum_pitch, {(2 * SH){1'b0}}};
      res_q[0][0] <= '0;
      res_q[1][0] <= '0;
      sq_x[0]     <= s1_x;
      sq_y[0]     <= s1_y;
      sq_z[0]     <= s1_z;
      for (int k = 0; k < ISQ_STEPS; k++) begin
        sq_x[k+1] <= sq_x[k];
        sq_y[k+1] <= sq_y[k];
        sq_z[k+1] <= sq_z[k];
        for (int l = 0; l < 2; l++) begin
          if (rem_q[l][k] >= trial[l][k]) begin
            rem_q[l][k+1] <= rem_q[l][k] - trial[l][k];
            res_q[l][k+1] <= (res_q[l][k] >> 1) + isq_bit(k);
          end else begin
            rem_q[l][k+1] <= rem_q[l][k];
            res_q[l][k+1] <= res_q[l][k] >> 1;
          end
        end
      end
    end
  end

  // Roll and pitch angles, numerators scaled to match the root.
  logic signed [TW-1:0]    roll_num, roll_den, pitch_num, pitch_den;
  logic                    roll_v, pitch_v;
  logic signed [ANG_W-1:0] roll, pitch;
  logic [2*SW-1:0]         ra_aux;
  logic signed [SW-1:0]    pa_z;

  assign roll_num  = TW'(sq_y[ISQ_STEPS]) <<< SH;
  assign pitch_num = TW'(sq_x[ISQ_STEPS]) <<< SH;
  assign roll_den  = $signed({1'b0, res_q[0][ISQ_STEPS][31:0]});
  assign pitch_den = $signed({1'b0, res_q[1][ISQ_STEPS][31:0]});

  thc_atan2 #(.W(TW), .STAGES(CORDIC_STAGES), .AUX_W(2 * SW)) u_roll (
    .clk(clk), .rst(rst), .en(en), .in_v(sq_v[ISQ_STEPS]),
    .num(roll_num), .den(roll_den),
    .aux_in({sq_x[ISQ_STEPS], sq_y[ISQ_STEPS]}),
    .out_v(roll_v), .angle(roll), .aux_out(ra_aux)
  );

  thc_atan2 #(.W(TW), .STAGES(CORDIC_STAGES), .AUX_W(SW)) u_pitch (
    .clk(clk), .rst(rst), .en(en), .in_v(sq_v[ISQ_STEPS]),
    .num(pitch_num), .den(pitch_den),
    .aux_in(sq_z[ISQ_STEPS]),
    .out_v(pitch_v), .angle(pitch), .aux_out(pa_z)
  );

  // Sine and cosine of roll and of the negated pitch.
  logic signed [ANG_W-1:0]  neg_pitch;
  logic                     scr_v, scp_v;
  logic signed [TRIG_W-1:0] cr, sr, cp, sp;
  logic [2*SW-1:0]          sc_aux;
  logic signed [SW-1:0]     sc_z;

  assign neg_pitch = -pitch;

  thc_sincos #(.STAGES(CORDIC_STAGES), .AUX_W(2 * SW)) u_sc_roll (
    .clk(clk), .rst(rst), .en(en), .in_v(roll_v), .ang(roll),
    .aux_in(ra_aux), .out_v(scr_v), .cos_q(cr), .sin_q(sr), .aux_out(sc_aux)
  );

  thc_sincos #(.STAGES(CORDIC_STAGES), .AUX_W(SW)) u_sc_pitch (
    .clk(clk), .rst(rst), .en(en), .in_v(pitch_v), .ang(neg_pitch),
    .aux_in(pa_z), .out_v(scp_v), .cos_q(cp), .sin_q(sp), .aux_out(sc_z)
  );

  // Rotation products over three stages: trig products and direct terms,
  // then the floored trig products times the samples, then the final sum.
  logic signed [SW-1:0]       sc_x, sc_y;
  logic                       p1_v, p2_v, p3_v;
  logic signed [2*TRIG_W-1:0] p1_t1, p1_t2;
  logic signed [PW-1:0]       p1_xcp, p1_zsp, p1_ycr, p2_ycr;
  logic signed [SW-1:0]       p1_x, p1_z;
  logic signed [W2-1:0]       p2_x2, p3_x2, p3_y2;
  logic signed [MW-1:0]       p2_m1, p2_m2, y_full;

  assign sc_x   = $signed(sc_aux[2*SW-1:SW]);
  assign sc_y   = $signed(sc_aux[SW-1:0]);
  assign y_full = p2_m1 + MW'(p2_ycr) - p2_m2;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
      p3_v <= 1'b0;
    end else if (en) begin
      p1_v <= scr_v;
      p2_v <= p1_v;
      p3_v <= p2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_t1  <= sr * sp;
      p1_t2  <= sr * cp;
      p1_xcp <= sc_x * cp;
      p1_zsp <= sc_z * sp;
      p1_ycr <= sc_y * cr;
      p1_x   <= sc_x;
      p1_z   <= sc_z;
      p2_x2  <= W2'(p1_xcp + p1_zsp);
      p2_m1  <= p1_x * $signed(p1_t1[2*TRIG_W-1:16]);
      p2_m2  <= p1_z * $signed(p1_t2[2*TRIG_W-1:16]);
      p2_ycr <= p1_ycr;
      p3_x2  <= p2_x2;
      p3_y2  <= $signed(y_full[W2-1:0]);
    end
  end

  // Heading angle; the zero-vector flag rides along for checking.
  logic                    fin_v;
  logic signed [ANG_W-1:0] fin_ang;
  logic                    fin_zero;

  thc_atan2 #(.W(W2), .STAGES(CORDIC_STAGES), .AUX_W(1)) u_heading (
    .clk(clk), .rst(rst), .en(en), .in_v(p3_v),
    .num(p3_x2), .den(p3_y2),
    .aux_in((p3_x2 == '0) && (p3_y2 == '0)),
    .out_v(fin_v), .angle(fin_ang), .aux_out(fin_zero)
  );

  // Conversion to centidegrees: scale the magnitude, round half away, clamp.
  logic                 c1_v, c1_neg;
  logic [CPW-1:0]       c1_prod;
  logic [ANG_W-1:0]     mag;
  logic [CPW:0]         rounded;
  logic [CPW-32:0]      cd;
  logic [15:0]          cd_clamped;

  assign mag        = fin_ang[ANG_W-1] ? $unsigned(-fin_ang) : $unsigned(fin_ang);
  assign rounded    = {1'b0, c1_prod} + (CPW + 1)'(64'd1 << 31);
  assign cd         = rounded[CPW:32];
  assign cd_clamped = (cd > (CPW - 31)'(CD_MAX)) ? CD_MAX : cd[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_v <= 1'b0;
      c2_v <= 1'b0;
    end else if (en) begin
      c1_v <= fin_v;
      c2_v <= c1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_neg           <= fin_ang[ANG_W-1];
      c1_prod          <= mag * CD_PER_RAD;
      heading_centideg <= c1_neg ? -$signed(cd_clamped) : $signed(cd_clamped);
    end
  end

  // The parallel roll and pitch chains must stay in step.
  assert property (@(posedge clk) disable iff (rst) roll_v == pitch_v)
    else $error("roll and pitch angle pipelines out of step");

  assert property (@(posedge clk) disable iff (rst) scr_v == scp_v)
    else $error("roll and pitch sine/cosine pipelines out of step");

  // A zero rotated vector must produce a zero heading angle.
  assert property (@(posedge clk) disable iff (rst) (fin_v && fin_zero) |-> (fin_ang == '0))
    else $error("zero vector did not give a zero heading angle");

  // A delivered heading lies within half a turn.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (heading_centideg <= 16'sd18000) && (heading_centideg >= -16'sd18000))
    else $error("heading outside +/-180 degrees");

endmodule

>>> hw/rtl/thc_atan2.sv
// ---------------------------------------------------------------------------
// thc_atan2
// Pipelined vectoring CORDIC: atan2(num, den) in Q16 radians, one stage per
// iteration, with a pre-turn by pi when the denominator is negative.
// ---------------------------------------------------------------------------
module thc_atan2 import thc_pkg::*; #(
  parameter int W      = 33,
  parameter int STAGES = 16,
  parameter int AUX_W  = 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_v,
  input  logic signed [W-1:0]     num,
  input  logic signed [W-1:0]     den,
  input  logic [AUX_W-1:0]        aux_in,
  output logic                    out_v,
  output logic signed [ANG_W-1:0] angle,
  output logic [AUX_W-1:0]        aux_out
);

  // Two guard bits cover the CORDIC gain and the negation in the pre-turn.
  localparam int XW = W + 2;

  logic signed [XW-1:0]    xs [STAGES+1];
  logic signed [XW-1:0]    ys [STAGES+1];
  logic signed [ANG_W-1:0] zs [STAGES+1];
  logic [AUX_W-1:0]        aux_s [STAGES+1];
  logic [STAGES:0]         zero_s;
  logic [STAGES:0]         vs;
  logic signed [XW-1:0]    num_x;
  logic signed [XW-1:0]    den_x;

  assign num_x = XW'(num);
  assign den_x = XW'(den);

  // Valid bits move with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= '0;
    end else if (en) begin
      vs <= {vs[STAGES-1:0], in_v};
    end
  end

  // Pre-turn stage, then one micro-rotation per stage.
  always_ff @(posedge clk) begin
    if (en) begin
      zero_s[0] <= (num == '0) && (den == '0);
      aux_s[0]  <= aux_in;
      if (den < 0) begin
        xs[0] <= -den_x;
        ys[0] <= -num_x;
        zs[0] <= (num >= 0) ? PI_Q16 : -PI_Q16;
      end else begin
        xs[0] <= den_x;
        ys[0] <= num_x;
        zs[0] <= '0;
      end
      for (int i = 0; i < STAGES; i++) begin
        zero_s[i+1] <= zero_s[i];
        aux_s[i+1]  <= aux_s[i];
        if (ys[i] > 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + ATAN_TABLE[i];
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - ATAN_TABLE[i];
        end
      end
    end
  end

  // A zero vector gives an angle of zero.
  assign out_v   = vs[STAGES];
  assign angle   = zero_s[STAGES] ? '0 : zs[STAGES];
  assign aux_out = aux_s[STAGES];

endmodule

>>> hw/rtl/thc_sincos.sv
// ---------------------------------------------------------------------------
// thc_sincos
// Pipelined rotation CORDIC: cosine and sine of a Q16 angle, gain
// pre-compensated, one stage per iteration.
// ---------------------------------------------------------------------------
module thc_sincos import thc_pkg::*; #(
  parameter int STAGES = 16,
  parameter int AUX_W  = 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_v,
  input  logic signed [ANG_W-1:0]  ang,
  input  logic [AUX_W-1:0]         aux_in,
  output logic                     out_v,
  output logic signed [TRIG_W-1:0] cos_q,
  output logic signed [TRIG_W-1:0] sin_q,
  output logic [AUX_W-1:0]         aux_out
);

  logic signed [TRIG_W-1:0] xs [STAGES+1];
  logic signed [TRIG_W-1:0] ys [STAGES+1];
  logic signed [ANG_W-1:0]  zs [STAGES+1];
  logic [AUX_W-1:0]         aux_s [STAGES+1];
  logic [STAGES:0]          vs;

  // Valid bits move with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= '0;
    end else if (en) begin
      vs <= {vs[STAGES-1:0], in_v};
    end
  end

  // Load stage, then one micro-rotation per stage driven by the angle sign.
  always_ff @(posedge clk) begin
    if (en) begin
      xs[0]    <= GAIN_INV_Q16;
      ys[0]    <= '0;
      zs[0]    <= ang;
      aux_s[0] <= aux_in;
      for (int i = 0; i < STAGES; i++) begin
        aux_s[i+1] <= aux_s[i];
        if (zs[i] >= 0) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - ATAN_TABLE[i];
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + ATAN_TABLE[i];
        end
      end
    end
  end

  assign out_v   = vs[STAGES];
  assign cos_q   = xs[STAGES];
  assign sin_q   = ys[STAGES];
  assign aux_out = aux_s[STAGES];

endmodule
